// ===== sv/ufl_pkg.sv =====
package ufl_pkg;

  // Default strip capacity and the depth of the tick queue
  localparam int MAX_LEDS_DEF = 256;
  localparam int QUEUE_DEPTH  = 4;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_LED_COUNT    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_HIGH    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ONE_HIGH     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TIMEOUT = 3'd4;

  // Register reset values
  localparam logic [8:0]  LED_COUNT_RST    = 9'd150;
  localparam logic [7:0]  ZERO_HIGH_RST    = 8'd3;
  localparam logic [7:0]  ONE_HIGH_RST     = 8'd5;
  localparam logic [7:0]  BIT_PERIOD_RST   = 8'd12;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd8192;

  typedef struct packed {
    logic [8:0]  led_count;
    logic [7:0]  zero_high_ticks;
    logic [7:0]  one_high_ticks;
    logic [7:0]  bit_period_ticks;
    logic [15:0] idle_timeout_ticks;
  } ufl_cfg_t;

  // One classified tick as it travels from the front to the back
  typedef struct packed {
    logic       is_byte;
    logic [7:0] data;
  } ufl_item_t;

endpackage

// ===== sv/ufl_if.sv =====
interface ufl_rx_if;
  logic       valid;
  logic       ready;
  logic       rx_valid;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_valid, output rx_byte, input ready);
  modport sink(input valid, input rx_valid, input rx_byte, output ready);
endinterface

interface ufl_led_if;
  logic valid;
  logic ready;
  logic line_level;
  logic sending;

  modport source(output valid, output line_level, output sending, input ready);
  modport sink(input valid, input line_level, input sending, output ready);
endinterface

// ===== sv/uart_frame_to_led_pulse_driver.sv =====
// Single-wire LED strip driver fed by a received serial byte stream.
//
// Channels: rx carries one transaction per clock tick of the strip timing
// (rx_valid flags a byte in rx_byte). led returns exactly one transaction
// per rx transaction, in order: line_level to drive on the data line and
// sending, high while a frame goes out.
// Configuration: cfg_we/cfg_index/cfg_data write LED count, zero and one
// high times, bit period and idle timeout; write only while the block is
// idle. Unknown indexes are ignored.
// Throughput: one transaction per cycle while led is ready; the back end
// advances the pixel state per accepted tick and prefetches the next pixel
// byte from the buffer's registered read port at least eight ticks ahead.
// Path: an accepted rx transaction is written into the queue, then the
// back-end step registers its result into the output register for led.
// Stalls: when led is not ready, the output register holds and the
// four-entry tick queue absorbs input; rx.ready drops once the queue fills.
// Reset: counters, indexes, flags clear, but the bit counter loads seven;
// registers take defaults; pixel buffer holds garbage until written.
module uart_frame_to_led_pulse_driver #(
  parameter int MAX_LEDS = ufl_pkg::MAX_LEDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  ufl_rx_if.sink                          rx,
  ufl_led_if.source                       led,
  input  logic                            cfg_we,
  input  logic [ufl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ufl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ufl_pkg::ufl_cfg_t  cfg;
  logic               q_valid;
  logic               q_ready;
  ufl_pkg::ufl_item_t q_item;

  // Configuration registers: decode the index, truncate data to each width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.led_count          <= ufl_pkg::LED_COUNT_RST;
      cfg.zero_high_ticks    <= ufl_pkg::ZERO_HIGH_RST;
      cfg.one_high_ticks     <= ufl_pkg::ONE_HIGH_RST;
      cfg.bit_period_ticks   <= ufl_pkg::BIT_PERIOD_RST;
      cfg.idle_timeout_ticks <= ufl_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ufl_pkg::CFG_LED_COUNT:    cfg.led_count          <= cfg_data[8:0];
        ufl_pkg::CFG_ZERO_HIGH:    cfg.zero_high_ticks    <= cfg_data[7:0];
        ufl_pkg::CFG_ONE_HIGH:     cfg.one_high_ticks     <= cfg_data[7:0];
        ufl_pkg::CFG_BIT_PERIOD:   cfg.bit_period_ticks   <= cfg_data[7:0];
        ufl_pkg::CFG_IDLE_TIMEOUT: cfg.idle_timeout_ticks <= cfg_data[15:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Front: accept and classify ticks into a short queue
  ufl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  // Back: store bytes, run the frame timing, hold the result register
  ufl_back #(
    .MAX_LEDS (MAX_LEDS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .led     (led)
  );

endmodule

// ===== sv/ufl_front.sv =====
module ufl_front (
  input  logic              clk,
  input  logic              rst,
  ufl_rx_if.sink            rx,
  output logic              q_valid,
  input  logic              q_ready,
  output ufl_pkg::ufl_item_t q_item
);

  localparam int PTR_W = $clog2(ufl_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(ufl_pkg::QUEUE_DEPTH + 1);

  ufl_pkg::ufl_item_t entries [ufl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;
  ufl_pkg::ufl_item_t item_in;

  assign rx.ready = (count != CNT_W'(ufl_pkg::QUEUE_DEPTH));
  assign push     = rx.valid && rx.ready;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = entries[rd_ptr];

  // Classify: a tick either carries a byte or only advances time
  always_comb begin
    item_in.is_byte = rx.rx_valid;
    item_in.data    = rx.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/ufl_back.sv =====
module ufl_back #(
  parameter int MAX_LEDS = ufl_pkg::MAX_LEDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ufl_pkg::ufl_cfg_t  cfg,
  input  logic               q_valid,
  output logic               q_ready,
  input  ufl_pkg::ufl_item_t q_item,
  ufl_led_if.source          led
);

  localparam int BUF_DEPTH = 3 * MAX_LEDS;
  localparam int AW        = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  logic [7:0] mem [BUF_DEPTH];

  logic             step;
  logic             out_valid;
  logic             level_r;
  logic             busy_r;

  logic [CNT_W-1:0] n_leds;
  logic [CNT_W-1:0] flen;

  logic [CNT_W-1:0] write_index, write_index_next;
  logic [15:0]      idle_counter, idle_counter_next;
  logic             send_flag, send_flag_next;
  logic [CNT_W-1:0] send_idx, send_idx_next;
  logic [2:0]       bit_counter, bit_counter_next;
  logic [7:0]       tick_counter, tick_counter_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic [CNT_W-1:0] next_base, next_base_next;
  logic [1:0]       next_r, next_r_next;

  logic             level;
  logic             busy;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [CNT_W:0]   rd_addr_full;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;

  logic             cur_bit;
  logic [7:0]       high_ticks;
  logic [CNT_W-1:0] send_idx_inc;
  logic [1:0]       lane_off;

  assign q_ready    = !out_valid || led.ready;
  assign step       = q_valid && q_ready;
  assign led.valid      = out_valid;
  assign led.line_level = level_r;
  assign led.sending    = busy_r;

  // Frame length: LED count clamped to one and to the buffer capacity
  always_comb begin
    if (cfg.led_count == 9'd0) begin
      n_leds = CNT_W'(1);
    end else if (32'(cfg.led_count) > 32'(MAX_LEDS)) begin
      n_leds = CNT_W'(MAX_LEDS);
    end else begin
      n_leds = CNT_W'(cfg.led_count);
    end
    flen = CNT_W'({n_leds, 1'b0}) + n_leds;
  end

  // Wire order per LED is green, red, blue: triple offsets one, zero, two
  always_comb begin
    case (next_r)
      2'd0:    lane_off = 2'd1;
      2'd1:    lane_off = 2'd0;
      default: lane_off = 2'd2;
    endcase
    rd_addr_full = {1'b0, next_base} + (CNT_W+1)'(lane_off);
    if (rd_addr_full < (CNT_W+1)'(BUF_DEPTH)) begin
      rd_addr = rd_addr_full[AW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    write_index_next  = write_index;
    idle_counter_next = idle_counter;
    send_flag_next    = send_flag;
    send_idx_next     = send_idx;
    bit_counter_next  = bit_counter;
    tick_counter_next = tick_counter;
    shift_byte_next   = shift_byte;
    next_base_next    = next_base;
    next_r_next       = next_r;
    level             = 1'b0;
    busy              = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = write_index[AW-1:0];
    cur_bit           = shift_byte[bit_counter];
    high_ticks        = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
    send_idx_inc      = send_idx + CNT_W'(1);

    if (send_flag) begin
      level = (tick_counter < high_ticks);
      busy  = 1'b1;
      if (({1'b0, tick_counter} + 9'd1) >= {1'b0, cfg.bit_period_ticks}) begin
        tick_counter_next = '0;
        if (bit_counter == 3'd0) begin
          bit_counter_next = 3'd7;
          if (send_idx_inc >= flen) begin
            // Frame done: drop back to reception, point the read port at
            // the first byte of the next frame
            send_flag_next    = 1'b0;
            send_idx_next     = '0;
            idle_counter_next = '0;
            next_base_next    = '0;
            next_r_next       = 2'd0;
          end else begin
            send_idx_next   = send_idx_inc;
            shift_byte_next = rd_data;
            if (next_r == 2'd2) begin
              next_r_next    = 2'd0;
              next_base_next = next_base + CNT_W'(3);
            end else begin
              next_r_next = next_r + 2'd1;
            end
          end
        end else begin
          bit_counter_next = bit_counter - 3'd1;
        end
      end else begin
        tick_counter_next = tick_counter + 8'd1;
      end
    end else begin
      if (q_item.is_byte) begin
        if (write_index < flen) begin
          mem_we           = 1'b1;
          write_index_next = write_index + CNT_W'(1);
        end
        idle_counter_next = '0;
      end else begin
        idle_counter_next = idle_counter + 16'd1;
        if (idle_counter_next >= cfg.idle_timeout_ticks) begin
          write_index_next  = '0;
          idle_counter_next = '0;
        end
      end
      if (write_index_next >= flen) begin
        // Frame complete: load the first byte, start sending next tick and
        // prefetch the second byte
        write_index_next  = '0;
        idle_counter_next = '0;
        send_flag_next    = 1'b1;
        send_idx_next     = '0;
        bit_counter_next  = 3'd7;
        tick_counter_next = '0;
        shift_byte_next   = rd_data;
        next_base_next    = '0;
        next_r_next       = 2'd1;
      end
    end
  end

  // Pixel buffer: one write port, one registered read port with bypass
  always_ff @(posedge clk) begin
    if (step && mem_we) begin
      mem[mem_waddr] <= q_item.data;
    end
    if (step && mem_we && (mem_waddr == rd_addr)) begin
      rd_data <= q_item.data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      level_r <= level;
      busy_r  <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      write_index  <= '0;
      idle_counter <= '0;
      send_flag    <= 1'b0;
      send_idx     <= '0;
      bit_counter  <= 3'd7;
      tick_counter <= '0;
      shift_byte   <= '0;
      next_base    <= '0;
      next_r       <= 2'd0;
    end else begin
      if (step) begin
        out_valid    <= 1'b1;
        write_index  <= write_index_next;
        idle_counter <= idle_counter_next;
        send_flag    <= send_flag_next;
        send_idx     <= send_idx_next;
        bit_counter  <= bit_counter_next;
        tick_counter <= tick_counter_next;
        shift_byte   <= shift_byte_next;
        next_base    <= next_base_next;
        next_r       <= next_r_next;
      end else if (led.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== test/ufl_led_checker.sv =====
`timescale 1ns / 100ps

// Watches the rx and led channels, predicts the LED line for every accepted
// tick and compares it with the led transactions in order.
module ufl_led_checker #(
  parameter int MAX_LEDS = ufl_pkg::MAX_LEDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  ufl_rx_if                               rx,
  ufl_led_if                              led,
  input  logic                            cfg_we,
  input  logic [ufl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ufl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              errors,
  output int                              pending,
  output logic                            tx_active,
  output int                              frames,
  output int                              ticks
);
  import ufl_pkg::*;

  typedef struct packed {
    logic level;
    logic sending;
  } line_sample_t;

  line_sample_t line_q[$];

  // register copies
  logic [8:0]  r_leds;
  logic [7:0]  r_zero_hi;
  logic [7:0]  r_one_hi;
  logic [7:0]  r_period;
  logic [15:0] r_timeout;

  // strip state
  logic [7:0]  pix [0:3*MAX_LEDS-1];
  logic [9:0]  fill;
  logic [15:0] quiet;
  logic        tx_on;
  logic [9:0]  tx_pos;
  logic [2:0]  bit_sel;
  logic [7:0]  tick_cnt;
  logic [7:0]  cur_byte;

  initial begin
    errors = 0;
    frames = 0;
    ticks  = 0;
  end

  function automatic int frame_len();
    int n;
    n = int'(r_leds);
    if (n == 0) n = 1;
    if (n > MAX_LEDS) n = MAX_LEDS;
    return 3 * n;
  endfunction

  // Byte sent at position pos: green, red, blue are bytes 1, 0, 2 of a triple.
  function automatic logic [7:0] pixel_at(int pos);
    int addr;
    addr = (pos / 3) * 3;
    case (pos % 3)
      0:       addr = addr + 1;
      1:       addr = addr;
      default: addr = addr + 2;
    endcase
    if (addr >= 3 * MAX_LEDS) return 8'h00;
    return pix[addr];
  endfunction

  task automatic advance_strip(input logic has_byte, input logic [7:0] b);
    int           flen;
    logic [7:0]   hi;
    line_sample_t s;
    flen = frame_len();
    s    = '0;
    if (tx_on) begin
      hi        = cur_byte[bit_sel] ? r_one_hi : r_zero_hi;
      s.level   = (tick_cnt < hi);
      s.sending = 1'b1;
      if ({1'b0, tick_cnt} + 9'd1 >= {1'b0, r_period}) begin
        tick_cnt = 8'd0;
        if (bit_sel == 3'd0) begin
          tx_pos = tx_pos + 10'd1;
          if (int'(tx_pos) >= flen) begin
            tx_on   = 1'b0;
            tx_pos  = 10'd0;
            bit_sel = 3'd7;
            quiet   = 16'd0;
            frames++;
          end else begin
            cur_byte = pixel_at(int'(tx_pos));
            bit_sel  = 3'd7;
          end
        end else begin
          bit_sel = bit_sel - 3'd1;
        end
      end else begin
        tick_cnt = tick_cnt + 8'd1;
      end
    end else begin
      if (has_byte) begin
        // drop bytes past the frame length
        if (int'(fill) < flen) begin
          pix[fill] = b;
          fill      = fill + 10'd1;
        end
        quiet = 16'd0;
      end else begin
        quiet = quiet + 16'd1;
        if (quiet >= r_timeout) begin
          fill  = 10'd0;
          quiet = 16'd0;
        end
      end
      if (int'(fill) >= flen) begin
        fill     = 10'd0;
        quiet    = 16'd0;
        tx_on    = 1'b1;
        tx_pos   = 10'd0;
        bit_sel  = 3'd7;
        tick_cnt = 8'd0;
        cur_byte = pixel_at(0);
      end
    end
    line_q.push_back(s);
  endtask

  task automatic report_miss(input string what);
    if (errors < 10) $display("%0t ns: led transaction mismatch, %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    line_sample_t want;
    if (rst) begin
      r_leds    = LED_COUNT_RST;
      r_zero_hi = ZERO_HIGH_RST;
      r_one_hi  = ONE_HIGH_RST;
      r_period  = BIT_PERIOD_RST;
      r_timeout = IDLE_TIMEOUT_RST;
      fill      = 10'd0;
      quiet     = 16'd0;
      tx_on     = 1'b0;
      tx_pos    = 10'd0;
      bit_sel   = 3'd7;
      tick_cnt  = 8'd0;
      cur_byte  = 8'd0;
      line_q.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_LED_COUNT:    r_leds    = cfg_data[8:0];
          CFG_ZERO_HIGH:    r_zero_hi = cfg_data[7:0];
          CFG_ONE_HIGH:     r_one_hi  = cfg_data[7:0];
          CFG_BIT_PERIOD:   r_period  = cfg_data[7:0];
          CFG_IDLE_TIMEOUT: r_timeout = cfg_data[15:0];
          default: ;
        endcase
      end
      if (rx.valid === 1'b1 && rx.ready === 1'b1) begin
        ticks++;
        advance_strip(rx.rx_valid, rx.rx_byte);
      end
      if (led.valid === 1'b1 && led.ready === 1'b1) begin
        if (line_q.size() == 0) begin
          report_miss($sformatf("nothing expected, got level %b sending %b",
                                led.line_level, led.sending));
        end else begin
          want = line_q.pop_front();
          if (led.line_level !== want.level || led.sending !== want.sending)
            report_miss($sformatf("expected level %b sending %b, got level %b sending %b",
                                  want.level, want.sending, led.line_level, led.sending));
        end
      end
    end
    tx_active <= tx_on;
    pending   <= line_q.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ufl_pkg::*;

  localparam int HOLD_TICKS = 300;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ufl_rx_if  rx();
  ufl_led_if led();

  int   errors, pending, frames, ticks;
  logic tx_active;

  // Stimulus shaping: idle rates, the one long receiver hold-off, and what
  // the current register setting means for the size of a frame.
  int src_idle_pct  = 12;
  int snk_stall_pct = 85;
  bit hold_req      = 1'b0;
  bit hold_served   = 1'b0;
  int cur_flen      = 3 * int'(LED_COUNT_RST);
  int cur_timeout   = int'(IDLE_TIMEOUT_RST);
  int settings      = 0;
  int rx_items      = 0;

  uart_frame_to_led_pulse_driver #(.MAX_LEDS(MAX_LEDS_DEF)) DUT (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .led       (led),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ufl_led_checker #(.MAX_LEDS(MAX_LEDS_DEF)) checker_i (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .led       (led),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .tx_active (tx_active),
    .frames    (frames),
    .ticks     (ticks)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random; on request hold off once for a long stretch
  // so the tick queue fills and rx.ready drops while the sender keeps going.
  initial begin
    led.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        led.ready <= 1'b0;
        for (int n = 0; n < HOLD_TICKS; n++) @(posedge clk);
      end
      led.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Offer one tick and hold it until the block takes the transaction.
  // Ticks offered while no frame is going out count as stimulus items.
  task automatic offer(input logic has_byte, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    if (!tx_active) rx_items++;
    rx.valid    <= 1'b1;
    rx.rx_valid <= has_byte;
    rx.rx_byte  <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
  endtask

  // Keep ticking until the predicted frame is out. Mostly quiet ticks, with
  // some bytes that must be ignored while sending.
  task automatic drain_frame();
    do offer($urandom_range(99) < 15, 8'($urandom)); while (tx_active);
  endtask

  // Drop valid and wait until every tick has come back, then let the
  // pipeline settle before touching the registers.
  task automatic settle();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  task automatic set_regs(input int unsigned leds, input int unsigned zero_hi,
                          input int unsigned one_hi, input int unsigned period,
                          input int unsigned tmo);
    put_reg(CFG_LED_COUNT, leds);
    put_reg(CFG_ZERO_HIGH, zero_hi);
    put_reg(CFG_ONE_HIGH, one_hi);
    put_reg(CFG_BIT_PERIOD, period);
    put_reg(CFG_IDLE_TIMEOUT, tmo);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_flen    = 3 * ((leds == 0) ? 1 : ((leds > MAX_LEDS_DEF) ? MAX_LEDS_DEF : leds));
    cur_timeout = int'(tmo);
    settings++;
  endtask

  // Well-formed frame: rewind the write index with a quiet stretch when the
  // timeout is short enough, then a full frame with gaps under the timeout.
  task automatic send_frame();
    int gap_max;
    gap_max = (cur_timeout > 6) ? 5 : cur_timeout - 1;
    if (cur_timeout <= 64)
      repeat ((cur_timeout == 0) ? 1 : cur_timeout) offer(1'b0, 8'($urandom));
    for (int i = 0; i < cur_flen; i++) begin
      if (i != 0 && gap_max > 0 && $urandom_range(99) < 20)
        repeat ($urandom_range(1, gap_max)) offer(1'b0, 8'($urandom));
      offer(1'b1, 8'($urandom));
    end
    drain_frame();
  endtask

  initial begin
    rst       <= 1'b1;
    rx.valid  <= 1'b0;
    rx.rx_valid <= 1'b0;
    rx.rx_byte  <= 8'h00;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_LED_COUNT;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed part ----
    // One LED with the default bit timing. The first byte received is red,
    // so green comes out first from the second byte. A fourth byte lands
    // while the frame goes out and must be ignored.
    set_regs(1, 3, 5, 12, 4);
    offer(1'b1, 8'h00);
    offer(1'b1, 8'hFF);
    offer(1'b1, 8'hA5);
    offer(1'b1, 8'h3C);
    drain_frame();
    settle();

    // Zero LED count acts as one; period zero gives one-tick bits; a zero
    // high time never raises the line, a high time past the period holds it
    // for the whole bit; a zero timeout rewinds on every quiet tick.
    set_regs(0, 0, 255, 0, 0);
    offer(1'b1, 8'h5A);
    offer(1'b0, 8'h00);
    offer(1'b1, 8'h0F);
    offer(1'b1, 8'hF0);
    offer(1'b1, 8'h81);
    drain_frame();
    settle();

    // Hold four bytes of a two-LED frame, then shrink the strip to one LED:
    // the next byte is dropped and the first three held bytes go out at once.
    set_regs(2, 1, 1, 1, 3);
    offer(1'b1, 8'h11);
    offer(1'b1, 8'h22);
    offer(1'b1, 8'h33);
    offer(1'b1, 8'h44);
    settle();
    set_regs(1, 255, 2, 6, 3);
    offer(1'b1, 8'hEE);
    drain_frame();
    settle();

    // Idle timeout: two stray bytes, a quiet stretch that rewinds the write
    // index, then a clean frame.
    set_regs(1, 2, 4, 5, 3);
    offer(1'b1, 8'hAA);
    offer(1'b1, 8'hBB);
    repeat (3) offer(1'b0, 8'h00);
    offer(1'b1, 8'h01);
    offer(1'b1, 8'h02);
    offer(1'b1, 8'h03);
    drain_frame();

    // ---- Random part ----
    // Phases 0-3: sender mostly busy, receiver mostly stalled; 4-7 the other
    // way round; 8-11 no idling. Phase 9 runs the slowest bit period, phase
    // 10 a full strip past the LED limit with a long receiver hold-off.
    for (int ph = 0; ph < 12; ph++) begin
      int unsigned leds, per, zh, oh, tmo;
      int          target;
      settle();
      if (ph == 4) begin
        src_idle_pct  = 85;
        snk_stall_pct = 12;
      end
      if (ph == 8) begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      case (ph)
        9:  set_regs(1, $urandom_range(0, 255), $urandom_range(0, 255), 255,
                     $urandom_range(0, 20));
        10: set_regs(511, 1, 2, 2, 65535);
        11: set_regs($urandom_range(1, 3), $urandom_range(0, 1), $urandom_range(0, 1), 1, 1);
        default: begin
          // Mostly short strips and short bits keep frames cheap.
          leds = ($urandom_range(9) == 0) ? 0
               : $urandom_range(1, ($urandom_range(3) == 0) ? 5 : 2);
          per  = $urandom_range(0, 10);
          zh   = ($urandom_range(9) == 0) ? 255 : $urandom_range(0, per + 1);
          oh   = ($urandom_range(9) == 0) ? 255 : $urandom_range(0, per + 1);
          case ($urandom_range(4))
            0, 1:    tmo = $urandom_range(0, 6);
            2, 3:    tmo = $urandom_range(7, 40);
            default: tmo = $urandom_range(1) ? 65535 : $urandom_range(41, 65534);
          endcase
          set_regs(leds, zh, oh, per, tmo);
        end
      endcase

      if (ph == 9 || ph == 10) begin
        if (ph == 10) hold_req <= 1'b1;
        send_frame();
      end else begin
        target = rx_items + 60;
        while (rx_items < target) begin
          case ($urandom_range(99)) inside
            [0:69]: send_frame();
            [70:84]: begin
              // Broken frame: a partial run of bytes, then a quiet gap that
              // rewinds the index when the timeout is short.
              repeat ($urandom_range(1, cur_flen - 1)) offer(1'b1, 8'($urandom));
              if (cur_timeout <= 300) repeat (cur_timeout + 1) offer(1'b0, 8'($urandom));
              else repeat ($urandom_range(1, 8)) offer(1'b0, 8'($urandom));
              drain_frame();
            end
            default: begin
              // Noise: random ticks, finished off in case they complete a frame.
              repeat ($urandom_range(1, 20)) offer(1'($urandom_range(1)), 8'($urandom));
              drain_frame();
            end
          endcase
        end
      end
    end

    settle();
    $display("Covered %0d ticks (%0d offered while receiving) over %0d register settings;",
             ticks, rx_items, settings);
    $display("%0d LED frames went out, %0d mismatches.", frames, errors);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #30_000_000;
    $display("Timed out with %0d led transactions outstanding", pending);
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ufl_pkg.sv
sv/ufl_if.sv
sv/ufl_front.sv
sv/ufl_back.sv
sv/uart_frame_to_led_pulse_driver.sv
test/ufl_led_checker.sv
test/tb.sv
